[hdl/dpb_pkg.sv]
package dpb_pkg;

  localparam int unsigned DEPTH_W   = 16;
  localparam int unsigned INDEX_W   = 12;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned XY_W      = 24;
  localparam int unsigned NUM_W     = 2 * CFG_W;
  localparam int unsigned REM_W     = CFG_W + 1;
  localparam int unsigned QBITS     = XY_W;
  localparam int unsigned STEP_BITS = 2;
  localparam int unsigned DIV_STEPS = QBITS / STEP_BITS;
  // Divider entry stage, the quotient stages and the output register.
  localparam int unsigned DIV_LAT   = DIV_STEPS + 2;
  // From an accepted item to its result strobe: queue, product, divider.
  localparam int unsigned ITEM_LAT  = DIV_LAT + 2;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REG_CENTER_COL = 3'd0;
  localparam logic [2:0] REG_CENTER_ROW = 3'd1;
  localparam logic [2:0] REG_FOCAL_COL  = 3'd2;
  localparam logic [2:0] REG_FOCAL_ROW  = 3'd3;
  localparam logic [2:0] REG_MAX_DEPTH  = 3'd4;

  localparam logic [CFG_W-1:0] RST_CENTER = 16'd0;
  localparam logic [CFG_W-1:0] RST_FOCAL  = 16'd16;
  localparam logic [CFG_W-1:0] RST_MAXD   = 16'hFFFF;

  localparam logic [QBITS-1:0] SAT_POS = 24'h7FFFFF;
  localparam logic [QBITS-1:0] SAT_NEG = 24'h800000;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               depth_bad;
    logic [INDEX_W-1:0] column;
    logic [INDEX_W-1:0] row;
  } item_t;

  typedef struct packed {
    logic signed [XY_W-1:0] point_x;
    logic signed [XY_W-1:0] point_y;
    logic [DEPTH_W-1:0]     point_z;
  } result_t;

  // An accepted pixel after classification: offset magnitudes and signs.
  typedef struct packed {
    logic               neg_x;
    logic [CFG_W-1:0]   mag_x;
    logic               neg_y;
    logic [CFG_W-1:0]   mag_y;
    logic [DEPTH_W-1:0] depth;
  } work_t;

endpackage

[hdl/dpb_front.sv]
module dpb_front import dpb_pkg::*; #(
  parameter int unsigned IMAGE_DIM_MAX = 4096
) (
  input  logic             accept_i,
  input  item_t            item_i,
  input  logic [CFG_W-1:0] center_col_i,
  input  logic [CFG_W-1:0] center_row_i,
  input  logic [CFG_W-1:0] max_depth_i,
  output logic             push_o,
  output work_t            work_o
);

  localparam logic [16:0] DIM_LIM = 17'(IMAGE_DIM_MAX);

  logic             keep;
  logic [CFG_W-1:0] pos_x;
  logic [CFG_W-1:0] pos_y;

  always_comb begin
    keep = !item_i.depth_bad && (item_i.depth != '0) && (item_i.depth <= max_depth_i)
           && ({5'b0, item_i.column} < DIM_LIM) && ({5'b0, item_i.row} < DIM_LIM);
    push_o = accept_i && keep;
  end

  // Pixel indexes become Q12.4 before the principal point is taken off.
  always_comb begin
    pos_x = {item_i.column, 4'b0};
    pos_y = {item_i.row, 4'b0};
    work_o.neg_x = pos_x < center_col_i;
    work_o.mag_x = work_o.neg_x ? (center_col_i - pos_x) : (pos_x - center_col_i);
    work_o.neg_y = pos_y < center_row_i;
    work_o.mag_y = work_o.neg_y ? (center_row_i - pos_y) : (pos_y - center_row_i);
    work_o.depth = item_i.depth;
  end

endmodule

[hdl/dpb_fifo.sv]
module dpb_fifo import dpb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t wdata_i,
  input  logic  pop_i,
  output work_t rdata_o,
  output logic  empty_o,
  output logic  full_o
);

  work_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    empty_o  = cnt_q == '0;
    full_o   = cnt_q == QCNT_W'(QUEUE_DEPTH);
    do_push  = push_i && !full_o;
    do_pop   = pop_i && !empty_o;
    wr_ptr_d = do_push ? QPTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop ? QPTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = QCNT_W'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = QCNT_W'(cnt_q - 1'b1);
    end
    rdata_o = mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[hdl/dpb_div.sv]
module dpb_div import dpb_pkg::*; (
  input  logic                   clk_i,
  input  logic [NUM_W-1:0]       num_i,
  input  logic                   neg_i,
  input  logic [CFG_W-1:0]       focal_i,
  output logic signed [XY_W-1:0] coord_o
);

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QBITS-1:0] low;
    logic [QBITS-1:0] quo;
  } step_t;

  function automatic step_t div_step(step_t s, logic [REM_W-1:0] dvs);
    logic [REM_W:0] t;
    step_t          r;
    r = s;
    for (int b = 0; b < STEP_BITS; b++) begin
      t     = {r.rem, r.low[QBITS-1]};
      r.low = {r.low[QBITS-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        r.rem = REM_W'(t - {1'b0, dvs});
        r.quo = {r.quo[QBITS-2:0], 1'b1};
      end else begin
        r.rem = t[REM_W-1:0];
        r.quo = {r.quo[QBITS-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic [CFG_W-1:0]   f_eff;
  logic [REM_W-1:0]   dvs;
  logic [NUM_W:0]     nn;
  logic               ovf;
  step_t              entry;
  step_t              st_q  [DIV_STEPS+1];
  logic               ovf_q [DIV_STEPS+1];
  logic               neg_q [DIV_STEPS+1];
  logic [QBITS-1:0]   q_fin;
  logic [QBITS-1:0]   q_sat;
  logic signed [XY_W-1:0] coord_q;

  // Round to nearest: floor((2*num + f) / (2*f)). A zero focal length counts as one.
  always_comb begin
    f_eff = (focal_i == '0) ? CFG_W'(1) : focal_i;
    dvs   = {f_eff, 1'b0};
    nn    = {num_i, 1'b0} + {{(NUM_W-CFG_W+1){1'b0}}, f_eff};
    // The quotient needs more than QBITS bits exactly when the top part reaches the divisor.
    ovf   = {{(REM_W-(NUM_W+1-QBITS)){1'b0}}, nn[NUM_W:QBITS]} >= dvs;
    entry.rem = ovf ? '0 : {{(REM_W-(NUM_W+1-QBITS)){1'b0}}, nn[NUM_W:QBITS]};
    entry.low = nn[QBITS-1:0];
    entry.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    st_q[0]  <= entry;
    ovf_q[0] <= ovf;
    neg_q[0] <= neg_i;
    for (int s = 0; s < DIV_STEPS; s++) begin
      st_q[s+1]  <= div_step(st_q[s], dvs);
      ovf_q[s+1] <= ovf_q[s];
      neg_q[s+1] <= neg_q[s];
    end
  end

  always_comb begin
    q_fin = st_q[DIV_STEPS].quo;
    if (neg_q[DIV_STEPS]) begin
      q_sat = (ovf_q[DIV_STEPS] || q_fin > SAT_NEG) ? SAT_NEG : q_fin;
    end else begin
      q_sat = (ovf_q[DIV_STEPS] || q_fin > SAT_POS) ? SAT_POS : q_fin;
    end
  end

  always_ff @(posedge clk_i) begin
    coord_q <= neg_q[DIV_STEPS] ? signed'(XY_W'(-q_sat)) : signed'(q_sat);
  end

  assign coord_o = coord_q;

endmodule

[hdl/dpb_back.sv]
module dpb_back import dpb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  work_t            work_i,
  input  logic [CFG_W-1:0] focal_col_i,
  input  logic [CFG_W-1:0] focal_row_i,
  output logic             pop_o,
  output result_t          res_o,
  output logic             res_valid_o
);

  logic [NUM_W-1:0]   num_x_q;
  logic [NUM_W-1:0]   num_y_q;
  logic               neg_x_q;
  logic               neg_y_q;
  logic               vld_q [DIV_LAT+1];
  logic [DEPTH_W-1:0] z_q   [DIV_LAT+1];
  logic signed [XY_W-1:0] coord_x;
  logic signed [XY_W-1:0] coord_y;

  // The back end never stalls, so it takes an item whenever the queue has one.
  assign pop_o = valid_i;

  always_ff @(posedge clk_i) begin
    num_x_q <= NUM_W'(work_i.mag_x) * NUM_W'(work_i.depth);
    num_y_q <= NUM_W'(work_i.mag_y) * NUM_W'(work_i.depth);
    neg_x_q <= work_i.neg_x;
    neg_y_q <= work_i.neg_y;
    z_q[0]  <= work_i.depth;
    for (int k = 0; k < DIV_LAT; k++) begin
      z_q[k+1] <= z_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_LAT; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= valid_i;
      for (int k = 0; k < DIV_LAT; k++) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  dpb_div u_div_x (
    .clk_i   (clk_i),
    .num_i   (num_x_q),
    .neg_i   (neg_x_q),
    .focal_i (focal_col_i),
    .coord_o (coord_x)
  );

  dpb_div u_div_y (
    .clk_i   (clk_i),
    .num_i   (num_y_q),
    .neg_i   (neg_y_q),
    .focal_i (focal_row_i),
    .coord_o (coord_y)
  );

  always_comb begin
    res_o.point_x = coord_x;
    res_o.point_y = coord_y;
    res_o.point_z = z_q[DIV_LAT];
    res_valid_o   = vld_q[DIV_LAT];
  end

endmodule

[hdl/depth_pixel_backprojection.sv]
// Back-projects depth pixels to 3D points through a pinhole camera model. One item can be
// started every clock; a kept pixel gives its point on res_o with res_valid_o high for one
// cycle, after a queue slot, a register of multiplies and a divider that retires two quotient
// bits per stage. Rejected pixels (flagged bad, zero depth, depth above max_depth, or outside
// the image) give no result. Results cannot be held off, so they must be taken when shown.
// busy rises only if the input queue fills, which does not happen since the back end drains
// one item per cycle. Registers are written over APB and are meant to change only while no
// item is in flight.
module depth_pixel_backprojection import dpb_pkg::*; #(
  parameter int unsigned IMAGE_DIM_MAX = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  item_t             item_i,
  output result_t           res_o,
  output logic              res_valid_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CFG_W-1:0] center_col_q;
  logic [CFG_W-1:0] center_row_q;
  logic [CFG_W-1:0] focal_col_q;
  logic [CFG_W-1:0] focal_row_q;
  logic [CFG_W-1:0] max_depth_q;
  logic [2:0]       reg_idx;
  logic             wr_en;
  logic             accept;
  logic             push;
  work_t            work_in;
  work_t            work_out;
  logic             q_empty;
  logic             q_full;
  logic             pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_col_q <= RST_CENTER;
      center_row_q <= RST_CENTER;
      focal_col_q  <= RST_FOCAL;
      focal_row_q  <= RST_FOCAL;
      max_depth_q  <= RST_MAXD;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CENTER_COL: center_col_q <= pwdata[CFG_W-1:0];
        REG_CENTER_ROW: center_row_q <= pwdata[CFG_W-1:0];
        REG_FOCAL_COL:  focal_col_q  <= pwdata[CFG_W-1:0];
        REG_FOCAL_ROW:  focal_row_q  <= pwdata[CFG_W-1:0];
        REG_MAX_DEPTH:  max_depth_q  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CENTER_COL: prdata = {{(DATA_W-CFG_W){1'b0}}, center_col_q};
      REG_CENTER_ROW: prdata = {{(DATA_W-CFG_W){1'b0}}, center_row_q};
      REG_FOCAL_COL:  prdata = {{(DATA_W-CFG_W){1'b0}}, focal_col_q};
      REG_FOCAL_ROW:  prdata = {{(DATA_W-CFG_W){1'b0}}, focal_row_q};
      REG_MAX_DEPTH:  prdata = {{(DATA_W-CFG_W){1'b0}}, max_depth_q};
      default:        prdata = '0;
    endcase
  end

  assign busy   = q_full;
  assign accept = start && !busy;

  dpb_front #(
    .IMAGE_DIM_MAX (IMAGE_DIM_MAX)
  ) u_front (
    .accept_i     (accept),
    .item_i       (item_i),
    .center_col_i (center_col_q),
    .center_row_i (center_row_q),
    .max_depth_i  (max_depth_q),
    .push_o       (push),
    .work_o       (work_in)
  );

  dpb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (work_in),
    .pop_i   (pop),
    .rdata_o (work_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  dpb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (!q_empty),
    .work_i      (work_out),
    .focal_col_i (focal_col_q),
    .focal_row_i (focal_row_q),
    .pop_o       (pop),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  // A point is never made from a zero depth.
  a_nonzero_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.point_z != '0)
    else $error("result with zero depth");

  // A kept item shows up a fixed number of cycles later carrying its own depth.
  a_kept_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> ##ITEM_LAT (res_valid_o && res_o.point_z == $past(item_i.depth, ITEM_LAT)))
    else $error("kept item lost or out of place");

  // A rejected item leaves its result slot empty.
  a_drop_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !push) |-> ##ITEM_LAT !res_valid_o)
    else $error("rejected item produced a result");

  // The back end drains every cycle, so the queue never fills.
  a_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty |=> !q_full)
    else $error("input queue filled");

endmodule
